>>> src/swt_pkg.sv
package swt_pkg;

	// Default sizes for the top level parameters
	localparam int TABLE_DEPTH_DEF = 2048;
	localparam int KEY_CHARS_DEF   = 8;

	// Longest search, in probes
	localparam int MAX_RESULTS = 12;

	// Fixed field widths of the channels
	localparam int WORD_W        = 64;
	localparam int INDEX_W       = 11;
	localparam int ENTRY_COUNT_W = 12;
	localparam int ITER_W        = 4;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_INSERT = 2'd1,
		OP_SEARCH = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_PUT,
		ST_DONE,
		ST_DROP,
		ST_RDATA,
		ST_PROBE,
		ST_CMP
	} state_t;

	typedef struct packed {
		op_t                 operation;
		logic [WORD_W-1:0]   word;
		logic [INDEX_W-1:0]  index;
	} req_t;

	typedef struct packed {
		logic [ENTRY_COUNT_W-1:0] entry_count;
		logic                     dropped;
		logic                     probe_valid;
		logic [INDEX_W-1:0]       probe_index;
		logic                     found;
		logic [ITER_W-1:0]        iterations;
		logic [WORD_W-1:0]        read_word;
		logic                     last;
	} rsp_t;

	// Top level to engine
	typedef struct packed {
		logic start;
		logic res_taken;
	} eng_ctl_t;

	// Engine to top level
	typedef struct packed {
		logic ready;
		logic res_valid;
	} eng_sts_t;

endpackage

>>> src/sorted_word_table_search.sv
// Channel | Valid     | Stall     | Payload
// req     | req_valid | req_stall | req (operation, word, index)
// rsp     | rsp_valid | rsp_stall | rsp (entry_count .. last)
//
// One transaction at a time; a new request is taken while a result waits in the output register.
// Insert moves the entries greater than the key up one place (one table write per cycle),
// then writes the key; into an empty table it writes the key at once.
// Search: each probe is a table read, then a compare, at most 12 probes.
// Reset clears state and entry count; the table has no reset value and needs no clearing pass.
// A stalled result holds the engine at its current step until taken.
module sorted_word_table_search import swt_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int KEY_CHARS   = KEY_CHARS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	eng_ctl_t ctl;
	eng_sts_t sts;
	rsp_t     res;
	logic     rsp_valid_q;
	rsp_t     rsp_q;
	logic     slot_free;

	assign slot_free     = !rsp_valid_q || !rsp_stall;
	assign req_stall     = !sts.ready;
	assign ctl.start     = req_valid && sts.ready;
	assign ctl.res_taken = slot_free;

	swt_engine #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.KEY_CHARS  (KEY_CHARS)
	) u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.item  (req),
		.sts   (sts),
		.res   (res)
	);

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (sts.res_valid && slot_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sts.res_valid && slot_free) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> src/swt_engine.sv
module swt_engine import swt_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int KEY_CHARS   = KEY_CHARS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  eng_ctl_t ctl,
	input  req_t     item,
	output eng_sts_t sts,
	output rsp_t     res
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;
	localparam logic [WORD_W-1:0] KEY_MASK = {WORD_W{1'b1}} << (WORD_W - 8 * KEY_CHARS);

	// Word table, one write and one registered read per cycle
	logic [WORD_W-1:0] mem [TABLE_DEPTH];
	logic [WORD_W-1:0] rd_data_q;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [WORD_W-1:0] wr_data;

	state_t            state_q, state_d;
	logic [CW-1:0]     count_q, count_d;
	logic [WORD_W-1:0] key_q, key_d;
	logic              hit_q, hit_d;
	logic [AW-1:0]     rp_q, rp_d;
	logic [CW-1:0]     lo_q, lo_d;
	logic [CW-1:0]     hi1_q, hi1_d;
	logic [AW-1:0]     mid_q, mid_d;
	logic [ITER_W-1:0] n_q, n_d;

	logic [CW:0]       mid_sum;
	logic [AW-1:0]     probe_mid;
	logic [CW-1:0]     mid_w;
	logic              cmp_eq;
	logic              cmp_lt;
	logic              search_end;
	logic [WORD_W-1:0] new_key;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Search window arithmetic: window is [lo, hi1)
	assign mid_sum    = {1'b0, lo_q} + {1'b0, hi1_q} - 1'b1;
	assign probe_mid  = AW'(mid_sum >> 1);
	assign mid_w      = CW'(mid_q);
	assign cmp_eq     = (key_q == rd_data_q);
	assign cmp_lt     = (key_q < rd_data_q);
	assign search_end = cmp_eq || (n_q == ITER_W'(MAX_RESULTS)) ||
		(cmp_lt ? (lo_q >= mid_w) : ((mid_w + 1'b1) >= hi1_q));
	assign new_key    = item.word & KEY_MASK;

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// Working registers of the current transaction
	always_ff @(posedge clk) begin
		key_q <= key_d;
		hit_q <= hit_d;
		rp_q  <= rp_d;
		lo_q  <= lo_d;
		hi1_q <= hi1_d;
		mid_q <= mid_d;
		n_q   <= n_d;
	end

	// Sequence clear, insert, search and read over the table
	always_comb begin
		state_d         = state_q;
		count_d         = count_q;
		key_d           = key_q;
		hit_d           = hit_q;
		rp_d            = rp_q;
		lo_d            = lo_q;
		hi1_d           = hi1_q;
		mid_d           = mid_q;
		n_d             = n_q;
		rd_en           = 1'b0;
		rd_addr         = '0;
		wr_en           = 1'b0;
		wr_addr         = '0;
		wr_data         = rd_data_q;
		res             = '0;
		res.entry_count = ENTRY_COUNT_W'(count_q);
		sts.ready       = 1'b0;
		sts.res_valid   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				sts.ready = 1'b1;
				if (ctl.start) begin
					key_d = new_key;
					unique case (item.operation)
						OP_CLEAR: begin
							count_d = '0;
							state_d = ST_DONE;
						end
						OP_INSERT: begin
							if (count_q >= CW'(TABLE_DEPTH)) begin
								state_d = ST_DROP;
							end else if (count_q == '0) begin
								wr_en   = 1'b1;
								wr_addr = '0;
								wr_data = new_key;
								count_d = count_q + 1'b1;
								state_d = ST_DONE;
							end else begin
								rd_en   = 1'b1;
								rd_addr = AW'(count_q - 1'b1);
								rp_d    = AW'(count_q - 1'b1);
								state_d = ST_SHIFT;
							end
						end
						OP_SEARCH: begin
							if (count_q == '0) begin
								state_d = ST_DONE;
							end else begin
								lo_d    = '0;
								hi1_d   = count_q;
								n_d     = '0;
								state_d = ST_PROBE;
							end
						end
						OP_READ: begin
							hit_d   = IW'(item.index) < IW'(count_q);
							rd_en   = IW'(item.index) < IW'(count_q);
							rd_addr = AW'(item.index);
							state_d = ST_RDATA;
						end
					endcase
				end
			end
			ST_SHIFT: begin
				// Move a greater entry up one place, or drop the key in above it
				wr_en   = 1'b1;
				wr_addr = rp_q + 1'b1;
				if (rd_data_q > key_q) begin
					wr_data = rd_data_q;
					if (rp_q == '0) begin
						state_d = ST_PUT;
					end else begin
						rd_en   = 1'b1;
						rd_addr = rp_q - 1'b1;
						rp_d    = rp_q - 1'b1;
					end
				end else begin
					wr_data = key_q;
					count_d = count_q + 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_PUT: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = key_q;
				count_d = count_q + 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				sts.res_valid = 1'b1;
				res.last      = 1'b1;
				if (ctl.res_taken) begin
					state_d = ST_IDLE;
				end
			end
			ST_DROP: begin
				sts.res_valid = 1'b1;
				res.dropped   = 1'b1;
				res.last      = 1'b1;
				if (ctl.res_taken) begin
					state_d = ST_IDLE;
				end
			end
			ST_RDATA: begin
				sts.res_valid = 1'b1;
				res.read_word = hit_q ? rd_data_q : '0;
				res.last      = 1'b1;
				if (ctl.res_taken) begin
					state_d = ST_IDLE;
				end
			end
			ST_PROBE: begin
				rd_en   = 1'b1;
				rd_addr = probe_mid;
				mid_d   = probe_mid;
				n_d     = n_q + 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				// Report this probe, then narrow the window or end the search
				sts.res_valid     = 1'b1;
				res.probe_valid   = 1'b1;
				res.probe_index   = INDEX_W'(mid_q);
				if (search_end) begin
					res.found      = cmp_eq;
					res.iterations = n_q;
					res.last       = 1'b1;
				end
				if (ctl.res_taken) begin
					if (search_end) begin
						state_d = ST_IDLE;
					end else begin
						if (cmp_lt) begin
							hi1_d = mid_w;
						end else begin
							lo_d = mid_w + 1'b1;
						end
						state_d = ST_PROBE;
					end
				end
			end
		endcase
	end

`ifndef SYNTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_shift_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> (CW'(rp_q) < count_q))
		else $error("shift pointer outside filled entries");

	a_probe_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> ((mid_w < count_q) && (n_q != '0) &&
			(n_q <= ITER_W'(MAX_RESULTS))))
		else $error("search probe outside table or probe count wrong");

	a_put_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUT) |=> (count_q == $past(count_q) + 1'b1))
		else $error("insert at bottom did not grow the table");
`endif

endmodule

>>> tb/swt_checker.sv
// Watches both channels of the sorted word table, keeps its own copy of the
// table, works out the results of every accepted request and compares them
// with the results the block hands out.
module swt_checker import swt_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int KEY_CHARS   = KEY_CHARS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp,
	output int   mismatch_count,
	output int   pending
);

	// Only the top KEY_CHARS bytes of a word take part in ordering
	localparam logic [WORD_W-1:0] KEY_MASK = {WORD_W{1'b1}} << (WORD_W - 8 * KEY_CHARS);

	logic [WORD_W-1:0] word_mem [TABLE_DEPTH];
	int                held_count;
	rsp_t              due_results [$];
	rsp_t              want_rsp;

	// Start every result from zero fields and the current entry count
	function automatic rsp_t count_only();
		rsp_t r;
		r = '0;
		r.entry_count = ENTRY_COUNT_W'(held_count);
		return r;
	endfunction

	// Update the table copy and queue the results one request causes
	task automatic apply_operation(input req_t t);
		logic [WORD_W-1:0] key;
		rsp_t              r;
		int                pos;
		int                lo;
		int                hi;
		int                mid;
		int                probes;
		logic              hit;
		logic              done;
		key = t.word & KEY_MASK;
		case (t.operation)
			OP_CLEAR: begin
				held_count = 0;
				r = count_only();
				r.last = 1'b1;
				due_results.push_back(r);
			end
			OP_INSERT: begin
				if (held_count >= TABLE_DEPTH) begin
					r = count_only();
					r.dropped = 1'b1;
				end else begin
					// shift greater entries up, land after equal ones
					pos = held_count;
					while (pos > 0 && word_mem[pos-1] > key) begin
						word_mem[pos] = word_mem[pos-1];
						pos--;
					end
					word_mem[pos] = key;
					held_count++;
					r = count_only();
				end
				r.last = 1'b1;
				due_results.push_back(r);
			end
			OP_READ: begin
				r = count_only();
				if (int'(t.index) < held_count)
					r.read_word = word_mem[t.index];
				r.last = 1'b1;
				due_results.push_back(r);
			end
			default: begin
				if (held_count == 0) begin
					// empty table: one result, no probe
					r = count_only();
					r.last = 1'b1;
					due_results.push_back(r);
				end else begin
					lo = 0;
					hi = held_count - 1;
					probes = 0;
					hit = 1'b0;
					done = 1'b0;
					while (!done) begin
						mid = (lo + hi) / 2;
						probes++;
						if (key == word_mem[mid])
							hit = 1'b1;
						else if (key < word_mem[mid])
							hi = mid - 1;
						else
							lo = mid + 1;
						done = hit || lo > hi || probes >= MAX_RESULTS;
						r = count_only();
						r.probe_valid = 1'b1;
						r.probe_index = INDEX_W'(mid);
						if (done) begin
							r.found = hit;
							r.iterations = ITER_W'(probes);
							r.last = 1'b1;
						end
						due_results.push_back(r);
					end
				end
			end
		endcase
	endtask

	// Count a failure, report only the first ten
	task automatic note_mismatch(input string what, input rsp_t want, input rsp_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t: result mismatch, %s", $realtime, what);
			$display("  expected: count=%0d dropped=%0b pvalid=%0b pindex=%0d found=%0b",
				want.entry_count, want.dropped, want.probe_valid, want.probe_index,
				want.found);
			$display("            iters=%0d read_word=%h last=%0b",
				want.iterations, want.read_word, want.last);
			$display("  actual:   count=%0d dropped=%0b pvalid=%0b pindex=%0d found=%0b",
				got.entry_count, got.dropped, got.probe_valid, got.probe_index,
				got.found);
			$display("            iters=%0d read_word=%h last=%0b",
				got.iterations, got.read_word, got.last);
		end
	endtask

	// Predict on each request transaction, compare on each result transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count = 0;
			due_results.delete();
			pending = 0;
		end else begin
			if (req_valid && !req_stall)
				apply_operation(req);
			if (rsp_valid && !rsp_stall) begin
				if (due_results.size() == 0) begin
					note_mismatch("result with nothing expected", '0, rsp);
				end else begin
					want_rsp = due_results.pop_front();
					if (rsp.entry_count !== want_rsp.entry_count
							|| rsp.dropped !== want_rsp.dropped
							|| rsp.probe_valid !== want_rsp.probe_valid
							|| rsp.probe_index !== want_rsp.probe_index
							|| rsp.found !== want_rsp.found
							|| rsp.iterations !== want_rsp.iterations
							|| rsp.read_word !== want_rsp.read_word
							|| rsp.last !== want_rsp.last)
						note_mismatch("field differs", want_rsp, rsp);
				end
			end
			pending = due_results.size();
		end
	end

endmodule

>>> tb/tb_top.sv
// Drives requests into the sorted word table, stalls results on a pattern of
// its own, and gives the verdict from the checker's failure count.
module tb_top;
	import swt_pkg::*;

	localparam int DEPTH        = TABLE_DEPTH_DEF;
	localparam int RANDOM_ITEMS = 205;
	localparam int FILL_ITEMS   = 48;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int TAIL_CYCLES  = 20;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req       = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;
	int          mismatch_count;
	int          pending;
	int          cycle_count = 0;
	int          burst_left  = 0;
	stall_mode_t stall_mode  = STALL_NONE;
	int          mode_left   = 0;
	logic [WORD_W-1:0] stored_words [$];

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	sorted_word_table_search DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	swt_checker result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.req            (req),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.rsp            (rsp),
		.mismatch_count (mismatch_count),
		.pending        (pending)
	);

	// Hold the receiver in one stall mode for a while, then pick another
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			mode_left <= $urandom_range(20, 120);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			STALL_NONE:  rsp_stall <= 1'b0;
			STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
			default:     rsp_stall <= ((cycle_count % 8) < 5);
		endcase
	end

	// End the run if it hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic [WORD_W-1:0] pack_word(input string s);
		logic [WORD_W-1:0] w;
		w = '0;
		for (int i = 0; i < s.len() && i < 8; i++)
			w[WORD_W-1-8*i -: 8] = s[i];
		return w;
	endfunction

	// Mostly short lower-case words (many repeats), sometimes raw 64-bit values
	function automatic logic [WORD_W-1:0] random_word();
		logic [WORD_W-1:0] w;
		int                len;
		int                span;
		w = '0;
		if ($urandom_range(0, 9) < 3) begin
			w = {$urandom, $urandom};
		end else begin
			len = $urandom_range(1, 8);
			span = ($urandom_range(0, 1) == 0) ? 4 : 26;
			for (int i = 0; i < len; i++)
				w[WORD_W-1-8*i -: 8] = 8'h61 + 8'($urandom_range(0, span - 1));
		end
		return w;
	endfunction

	// Ascending fill words: the top bits count up, the rest vary
	function automatic logic [WORD_W-1:0] fill_word(input int i);
		return {16'(i + 1), 48'h3C5A_96E1_0000 ^ 48'(i * 40503)};
	endfunction

	// Present one request transaction, in bursts with random gaps between them
	task automatic send(input op_t op, input logic [WORD_W-1:0] w, input logic [INDEX_W-1:0] idx);
		req_t t;
		int   gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		t.operation = op;
		t.word = w;
		t.index = idx;
		req <= t;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		burst_left--;
		// track table contents to aim searches and reads
		case (op)
			OP_CLEAR:  stored_words.delete();
			OP_INSERT: if (stored_words.size() < DEPTH) stored_words.push_back(w);
			default:   ;
		endcase
	endtask

	// Drop valid and wait until every expected result has come back
	task automatic wait_drained();
		req_valid <= 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic random_item();
		int                pick;
		logic [WORD_W-1:0] w;
		logic [INDEX_W-1:0] idx;
		pick = $urandom_range(0, 99);
		w = random_word();
		idx = INDEX_W'($urandom_range(0, DEPTH - 1));
		if (stored_words.size() >= 150 || pick < 3) begin
			send(OP_CLEAR, w, idx);
		end else if (pick < 40) begin
			send(OP_INSERT, w, idx);
		end else if (pick < 72) begin
			if (stored_words.size() > 0 && $urandom_range(0, 9) < 6)
				w = stored_words[$urandom_range(0, stored_words.size() - 1)];
			send(OP_SEARCH, w, idx);
		end else begin
			// aim near the filled range, one past the end included
			if ($urandom_range(0, 9) < 7)
				idx = INDEX_W'($urandom_range(0, stored_words.size()));
			send(OP_READ, w, idx);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: search, read
		send(OP_SEARCH, pack_word("apple"), '0);
		send(OP_READ, '1, '0);
		send(OP_READ, '0, '1);
		// Extreme words, equal words, out-of-order inserts
		send(OP_INSERT, '0, '1);
		send(OP_INSERT, '1, '0);
		send(OP_INSERT, pack_word("pear"), '0);
		send(OP_INSERT, pack_word("apple"), '0);
		send(OP_INSERT, pack_word("pear"), '0);
		send(OP_INSERT, pack_word("fig"), '0);
		send(OP_READ, '0, 11'd0);
		send(OP_READ, '0, 11'd2);
		send(OP_READ, '0, 11'd5);
		send(OP_READ, '0, 11'd6);
		send(OP_READ, '0, '1);
		send(OP_SEARCH, pack_word("pear"), '0);
		send(OP_SEARCH, pack_word("apple"), '0);
		send(OP_SEARCH, '0, '0);
		send(OP_SEARCH, '1, '0);
		send(OP_SEARCH, pack_word("grape"), '0);
		send(OP_SEARCH, pack_word("aaa"), '0);
		// Clear, then the empty cases again
		send(OP_CLEAR, '1, '1);
		send(OP_SEARCH, pack_word("fig"), '0);
		send(OP_READ, '0, 11'd0);

		for (int n = 0; n < RANDOM_ITEMS / 2; n++)
			random_item();

		wait_drained();

		// Fill in falling order so every insert shifts the whole table up
		send(OP_CLEAR, '0, '0);
		for (int i = 0; i < FILL_ITEMS; i++)
			send(OP_INSERT, fill_word(FILL_ITEMS - 1 - i),
				INDEX_W'($urandom_range(0, DEPTH - 1)));
		send(OP_INSERT, '0, '0);
		send(OP_INSERT, '1, '0);
		send(OP_INSERT, fill_word(5), '0);
		send(OP_SEARCH, fill_word(0), '0);
		send(OP_SEARCH, fill_word(FILL_ITEMS - 1), '0);
		send(OP_SEARCH, fill_word(FILL_ITEMS / 2), '0);
		send(OP_SEARCH, '0, '0);
		send(OP_SEARCH, '1, '0);
		send(OP_SEARCH, fill_word(20) + 64'd1, '0);
		send(OP_READ, '0, 11'd0);
		send(OP_READ, '0, INDEX_W'(FILL_ITEMS + 2));
		send(OP_READ, '0, INDEX_W'(FILL_ITEMS + 3));
		send(OP_CLEAR, '0, '0);

		for (int n = 0; n < RANDOM_ITEMS - RANDOM_ITEMS / 2; n++)
			random_item();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
		if (mismatch_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
